// ===== sv/sskey_pkg.sv =====
`timescale 1ns / 1ps
package sskey_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_BYTES   = 8;
  localparam int KEY_W       = 64;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;
  localparam int PTR_W       = CNT_W + 1;   // signed search pointers, -1 .. TABLE_DEPTH
  localparam int STEP_W      = 4;
  localparam int COND_W      = 4;
  localparam int ACT_W       = 4;
  localparam int RD_W        = 2;

  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);

  // input operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // condition select
  localparam logic [COND_W-1:0] COND_QUERY     = 4'd0;
  localparam logic [COND_W-1:0] COND_LO_GT_HI  = 4'd1;
  localparam logic [COND_W-1:0] COND_RD_ZERO   = 4'd2;
  localparam logic [COND_W-1:0] COND_KEY_EQ    = 4'd3;
  localparam logic [COND_W-1:0] COND_I_NEG     = 4'd4;
  localparam logic [COND_W-1:0] COND_KEY_LE    = 4'd5;
  localparam logic [COND_W-1:0] COND_I_GE_N    = 4'd6;
  localparam logic [COND_W-1:0] COND_KEY_GE    = 4'd7;
  localparam logic [COND_W-1:0] COND_OUT_FREE  = 4'd8;

  // datapath actions
  localparam logic [ACT_W-1:0] ACT_NOP    = 4'd0;
  localparam logic [ACT_W-1:0] ACT_START  = 4'd1;
  localparam logic [ACT_W-1:0] ACT_SET_MID = 4'd2;
  localparam logic [ACT_W-1:0] ACT_HIT    = 4'd3;
  localparam logic [ACT_W-1:0] ACT_MISS   = 4'd4;
  localparam logic [ACT_W-1:0] ACT_NARROW = 4'd5;
  localparam logic [ACT_W-1:0] ACT_I_DN   = 4'd6;
  localparam logic [ACT_W-1:0] ACT_I_UP   = 4'd7;
  localparam logic [ACT_W-1:0] ACT_DEC_I  = 4'd8;
  localparam logic [ACT_W-1:0] ACT_INC_I  = 4'd9;
  localparam logic [ACT_W-1:0] ACT_HI_I   = 4'd10;
  localparam logic [ACT_W-1:0] ACT_LO_I   = 4'd11;
  localparam logic [ACT_W-1:0] ACT_EMIT   = 4'd12;

  // table read address select
  localparam logic [RD_W-1:0] RD_NONE = 2'd0;
  localparam logic [RD_W-1:0] RD_MID  = 2'd1;
  localparam logic [RD_W-1:0] RD_I    = 2'd2;

  typedef struct packed {
    logic             operation;
    logic [IDX_W-1:0] entry_index;
    logic [KEY_W-1:0] key_value;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } out_item_t;

  // one microcode word
  typedef struct packed {
    logic [COND_W-1:0] cond;
    logic [ACT_W-1:0]  act_t;
    logic [ACT_W-1:0]  act_f;
    logic [RD_W-1:0]   rd_f;
    logic [STEP_W-1:0] next_t;
    logic [STEP_W-1:0] next_f;
    logic              accept;
  } ucode_t;

  // resolved control for the current cycle
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [RD_W-1:0]  rd_sel;
    logic             accept;
  } ctrl_t;

  typedef struct packed {
    logic lo_gt_hi;
    logic rd_zero;
    logic key_eq;
    logic i_neg;
    logic key_le;
    logic i_ge_n;
    logic key_ge;
  } flags_t;

endpackage

// ===== sv/sskey_seq.sv =====
`timescale 1ns / 1ps
module sskey_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  sskey_pkg::flags_t flags,
  input  logic              query_go,
  input  logic              out_free,
  output sskey_pkg::ctrl_t  ctrl
);
  import sskey_pkg::*;

  localparam logic [STEP_W-1:0] S_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] S_PROBE  = 4'd1;
  localparam logic [STEP_W-1:0] S_CHECK  = 4'd2;
  localparam logic [STEP_W-1:0] S_DN_RD  = 4'd3;
  localparam logic [STEP_W-1:0] S_DN_CHK = 4'd4;
  localparam logic [STEP_W-1:0] S_UP_RD  = 4'd5;
  localparam logic [STEP_W-1:0] S_UP_CHK = 4'd6;
  localparam logic [STEP_W-1:0] S_FIN    = 4'd7;
  localparam logic [STEP_W-1:0] S_CMP    = 4'd8;
  localparam logic [STEP_W-1:0] S_DN_TST = 4'd9;
  localparam logic [STEP_W-1:0] S_UP_TST = 4'd10;

  // cond, act on true, act on false, read on false, next on true, next on false, accept
  function automatic ucode_t rom_word(input logic [STEP_W-1:0] s);
    ucode_t w;
    case (s)
      S_IDLE:   w = '{COND_QUERY,    ACT_START,  ACT_NOP,     RD_NONE, S_PROBE, S_IDLE,   1'b1};
      S_PROBE:  w = '{COND_LO_GT_HI, ACT_MISS,   ACT_SET_MID, RD_MID,  S_FIN,   S_CHECK,  1'b0};
      S_CHECK:  w = '{COND_RD_ZERO,  ACT_I_DN,   ACT_NOP,     RD_NONE, S_DN_RD, S_CMP,    1'b0};
      S_CMP:    w = '{COND_KEY_EQ,   ACT_HIT,    ACT_NARROW,  RD_NONE, S_FIN,   S_PROBE,  1'b0};
      S_DN_RD:  w = '{COND_I_NEG,    ACT_I_UP,   ACT_NOP,     RD_I,    S_UP_RD, S_DN_CHK, 1'b0};
      S_DN_CHK: w = '{COND_RD_ZERO,  ACT_DEC_I,  ACT_NOP,     RD_NONE, S_DN_RD, S_DN_TST, 1'b0};
      S_DN_TST: w = '{COND_KEY_LE,   ACT_HI_I,   ACT_I_UP,    RD_NONE, S_PROBE, S_UP_RD,  1'b0};
      S_UP_RD:  w = '{COND_I_GE_N,   ACT_MISS,   ACT_NOP,     RD_I,    S_FIN,   S_UP_CHK, 1'b0};
      S_UP_CHK: w = '{COND_RD_ZERO,  ACT_INC_I,  ACT_NOP,     RD_NONE, S_UP_RD, S_UP_TST, 1'b0};
      S_UP_TST: w = '{COND_KEY_GE,   ACT_LO_I,   ACT_MISS,    RD_NONE, S_PROBE, S_FIN,    1'b0};
      S_FIN:    w = '{COND_OUT_FREE, ACT_EMIT,   ACT_NOP,     RD_NONE, S_IDLE,  S_FIN,    1'b0};
      default:  w = '{COND_QUERY,    ACT_NOP,    ACT_NOP,     RD_NONE, S_IDLE,  S_IDLE,   1'b0};
    endcase
    return w;
  endfunction

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  ucode_t            word;
  logic              cond_hit;

  assign word = rom_word(step_r);

  always_comb begin
    case (word.cond)
      COND_QUERY:    cond_hit = query_go;
      COND_LO_GT_HI: cond_hit = flags.lo_gt_hi;
      COND_RD_ZERO:  cond_hit = flags.rd_zero;
      COND_KEY_EQ:   cond_hit = flags.key_eq;
      COND_I_NEG:    cond_hit = flags.i_neg;
      COND_KEY_LE:   cond_hit = flags.key_le;
      COND_I_GE_N:   cond_hit = flags.i_ge_n;
      COND_KEY_GE:   cond_hit = flags.key_ge;
      COND_OUT_FREE: cond_hit = out_free;
      default:       cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    step_nxt    = cond_hit ? word.next_t : word.next_f;
    ctrl.act    = cond_hit ? word.act_t : word.act_f;
    ctrl.rd_sel = cond_hit ? RD_NONE : word.rd_f;
    ctrl.accept = word.accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == S_IDLE && !query_go) |=> step_r == S_IDLE)
    else $error("sequencer left idle without a query");

endmodule

// ===== sv/sskey_dp.sv =====
`timescale 1ns / 1ps
module sskey_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sskey_pkg::ctrl_t         ctrl,
  input  logic                     in_fire,
  input  sskey_pkg::in_item_t      in_item,
  input  logic                     cfg_we,
  input  logic [sskey_pkg::CNT_W-1:0] cfg_wdata,
  output sskey_pkg::flags_t        flags,
  output sskey_pkg::out_item_t     result
);
  import sskey_pkg::*;

  logic [KEY_W-1:0] mem [TABLE_DEPTH];
  logic [KEY_W-1:0] rd_data_r;
  logic [KEY_W-1:0] key_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] n_r;
  logic signed [PTR_W-1:0] lo_r;
  logic signed [PTR_W-1:0] hi_r;
  logic signed [PTR_W-1:0] i_r;
  logic [IDX_W-1:0] mid_r;
  logic             found_r;
  logic [IDX_W-1:0] pos_r;

  logic [CNT_W-1:0] n_sat;
  logic [PTR_W:0]   mid_sum;
  logic [IDX_W-1:0] mid_calc;
  logic [PTR_W-1:0] mid_ext;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;

  assign n_sat    = (cnt_r > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : cnt_r;
  assign mid_sum  = {lo_r[PTR_W-1], lo_r} + {hi_r[PTR_W-1], hi_r};
  assign mid_calc = mid_sum[IDX_W:1];   // both bounds nonnegative while probing
  assign mid_ext  = {{(PTR_W-IDX_W){1'b0}}, mid_r};
  assign rd_en    = (ctrl.rd_sel != RD_NONE);
  assign rd_addr  = (ctrl.rd_sel == RD_MID) ? mid_calc : i_r[IDX_W-1:0];
  assign wr_en    = in_fire && (in_item.operation == OP_LOAD)
                    && ({1'b0, in_item.entry_index} < CNT_W'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[in_item.entry_index] <= in_item.key_value & KEY_MASK;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    flags.lo_gt_hi = lo_r > hi_r;
    flags.rd_zero  = (rd_data_r == '0);
    flags.key_eq   = (key_r == rd_data_r);
    flags.i_neg    = i_r[PTR_W-1];
    flags.key_le   = (key_r <= rd_data_r);
    flags.i_ge_n   = i_r >= $signed({1'b0, n_r});
    flags.key_ge   = (key_r >= rd_data_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      lo_r  <= '0;
      hi_r  <= '0;
    end else begin
      if (cfg_we) begin
        cnt_r <= cfg_wdata;
      end
      case (ctrl.act)
        ACT_START: begin
          lo_r <= '0;
          hi_r <= $signed({1'b0, n_sat}) - PTR_W'(1);
        end
        ACT_NARROW: begin
          if (key_r < rd_data_r) begin
            hi_r <= $signed(mid_ext) - PTR_W'(1);
          end else begin
            lo_r <= $signed(mid_ext) + PTR_W'(1);
          end
        end
        ACT_HI_I: hi_r <= i_r;
        ACT_LO_I: lo_r <= i_r;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.act)
      ACT_START: begin
        key_r <= in_item.key_value & KEY_MASK;
        n_r   <= n_sat;
      end
      ACT_SET_MID: mid_r <= mid_calc;
      ACT_I_DN:    i_r <= $signed(mid_ext) - PTR_W'(1);
      ACT_I_UP:    i_r <= $signed(mid_ext) + PTR_W'(1);
      ACT_DEC_I:   i_r <= i_r - PTR_W'(1);
      ACT_INC_I:   i_r <= i_r + PTR_W'(1);
      ACT_HIT: begin
        found_r <= 1'b1;
        pos_r   <= mid_r;
      end
      ACT_MISS: begin
        found_r <= 1'b0;
        pos_r   <= '0;
      end
      default: ;
    endcase
  end

  assign result.found    = found_r;
  assign result.position = pos_r;

  // every probe and scan read stays inside the used part of the table
  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && ctrl.act != ACT_START) |-> ({1'b0, rd_addr} < n_r))
    else $error("table read beyond entry count");

  a_hit_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.act == ACT_HIT) |-> (rd_data_r == key_r && key_r != '0))
    else $error("hit reported on a key mismatch");

  a_no_read_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !rd_en)
    else $error("table load during a search");

endmodule

// ===== sv/sparse_sorted_key_search_top.sv =====
`timescale 1ns / 1ps
// Sorted key table (1024 x 64-bit, zero key = empty entry) with binary search that steps
// over empty entries. A load beat writes one entry and gives no result; a query beat
// gives one result (found, position). Each probe reads the middle entry, tests it for
// empty and compares it with the key. When a probe lands in a run of empty entries, the
// nearest filled neighbors are scanned one entry at a time, downward and where needed
// upward, and each filled neighbor found is tested against the key to narrow the bounds.
// The table is single-port with a registered read and is driven by a microcoded step
// sequencer. One query is in flight at a time; a finished result waits in the output
// register, and while that register is still full the sequencer holds the next result
// and takes no input. Table contents are undefined after reset: entries searched (below
// entry_count) must have been loaded first.
module sparse_sorted_key_search_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sskey_pkg::in_item_t           in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sskey_pkg::out_item_t          out_data,
  input  logic                          cfg_we,
  input  logic [sskey_pkg::CNT_W-1:0]   cfg_wdata
);
  import sskey_pkg::*;

  ctrl_t     ctrl;
  flags_t    flags;
  out_item_t result;
  logic      in_fire;
  logic      query_go;
  logic      out_free;
  logic      out_valid_r;
  out_item_t out_data_r;

  assign in_ready  = ctrl.accept;
  assign in_fire   = in_valid && in_ready;
  assign query_go  = in_valid && (in_data.operation == OP_QUERY);
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  sskey_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .flags    (flags),
    .query_go (query_go),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  sskey_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_fire   (in_fire),
    .in_item   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .flags     (flags),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.act == ACT_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.act == ACT_EMIT) begin
      out_data_r <= result;
    end
  end

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.operation == OP_QUERY) |=> !in_ready)
    else $error("input taken while a query is running");

endmodule
